/* src/hpwl_pkg.sv */
`timescale 1ns / 1ps

package hpwl_pkg;

    // Fixed field widths of the stream items
    localparam int IDX_W      = 16;
    localparam int VAL_W      = 32;
    localparam int NET_WL_W   = 33;
    localparam int TOTAL_W    = 64;

    // Slave side packing
    localparam int S_TDATA_W  = 80;
    localparam int S_TUSER_W  = 3;
    localparam int IDX_LSB    = 0;
    localparam int X_LSB      = IDX_LSB + IDX_W;
    localparam int Y_LSB      = X_LSB + VAL_W;

    localparam int TUSER_MODE     = 0;
    localparam int TUSER_ENABLE   = 1;
    localparam int TUSER_LAST_NET = 2;

    // Master side packing
    localparam int M_TDATA_W  = 104;
    localparam int NET_WL_LSB = 0;
    localparam int TOTAL_LSB  = NET_WL_LSB + NET_WL_W;
    localparam int M_PAD_W    = M_TDATA_W - TOTAL_LSB - TOTAL_W;

    // Item kinds carried in tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_PIN   = 1'b1;

    typedef logic [TOTAL_W-1:0]  total_t;
    typedef logic [NET_WL_W-1:0] net_wl_t;

endpackage

/* src/net_half_perimeter_wirelength.sv */
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                          tuser / tlast
// s_        in   cell_index[15:0] x_value[47:16]             tuser: mode, net_enabled,
//                y_value[79:48]                              last_net; tlast: last_pin
// m_        out  net_wirelength[32:0] total_wirelength[96:33] tlast: design_done
//                zeros[103:97]
//
// One transaction per cycle on s_ while s_tready is high, writes and pins alike. The
// position store is a single RAM holding {y, x}; a pin reads it at acceptance, and the
// bounding box updates from the read data when stage 1 fires. A result enters the
// output register, raising m_tvalid, once its last pin has passed stages 1, 2 and 3.
// Reset clears the running box, the total and all valid flags. The store is not
// cleared: no clearing pass, positions are undefined until written.
// s_tready falls only while stage 1 holds a last pin and stage 2, stage 3 and the
// output register are all full with m_tready low; then any transaction waits.

module net_half_perimeter_wirelength #(
    parameter int NUM_CELLS  = 65536,
    parameter int COORD_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hpwl_pkg::S_TDATA_W-1:0]   s_tdata,   // cell_index, x_value, y_value
    input  logic [hpwl_pkg::S_TUSER_W-1:0]   s_tuser,   // mode, net_enabled, last_net
    input  logic                             s_tlast,   // last_pin

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [hpwl_pkg::M_TDATA_W-1:0]   m_tdata,   // net_wirelength, total_wirelength, pad
    output logic                             m_tlast    // design_done
);

    localparam int AW  = $clog2(NUM_CELLS);
    localparam int CW  = COORD_BITS;
    localparam int WLW = COORD_BITS + 1;

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    logic [hpwl_pkg::IDX_W-1:0] in_idx;
    logic [hpwl_pkg::VAL_W-1:0] in_x;
    logic [hpwl_pkg::VAL_W-1:0] in_y;
    logic                       in_is_pin;
    logic                       in_range;
    logic                       accept;

    assign in_idx    = s_tdata[hpwl_pkg::IDX_LSB +: hpwl_pkg::IDX_W];
    assign in_x      = s_tdata[hpwl_pkg::X_LSB +: hpwl_pkg::VAL_W];
    assign in_y      = s_tdata[hpwl_pkg::Y_LSB +: hpwl_pkg::VAL_W];
    assign in_is_pin = (s_tuser[hpwl_pkg::TUSER_MODE] == hpwl_pkg::MODE_PIN);
    assign in_range  = (32'(in_idx) < NUM_CELLS);
    assign accept    = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Position store: {y, x}. A read never meets a write to the same
    // entry in one cycle since only one transaction enters per cycle.
    // ---------------------------------------------------------------
    logic [2*CW-1:0] rd_data;

    hpwl_ram #(
        .WIDTH (2 * CW),
        .DEPTH (NUM_CELLS)
    ) u_pos_ram (
        .clk     (aclk),
        .wr_en   (accept && !in_is_pin && in_range),
        .wr_addr (AW'(in_idx)),
        .wr_data ({CW'(in_y), CW'(in_x)}),
        .rd_en   (accept && in_is_pin),
        .rd_addr (AW'(in_idx)),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Pipeline control
    // ---------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic s1_in_range_reg, s1_last_reg, s1_enabled_reg, s1_last_net_reg;
    logic out_free, s3_free, s2_free, s1_free;
    logic s1_fire, s1_close, s2_move, s3_move;

    assign out_free = !m_valid_reg || m_tready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || !s1_last_reg || s2_free;
    assign s_tready = s1_free;

    assign s1_fire  = s1_valid_reg && s1_free;
    assign s1_close = s1_fire && s1_last_reg;
    assign s2_move  = s2_valid_reg && s3_free;
    assign s3_move  = s3_valid_reg && out_free;

    // Stage 1: pin flags alongside the RAM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= accept && in_is_pin;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_free) begin
            s1_in_range_reg <= in_range;
            s1_last_reg     <= s_tlast;
            s1_enabled_reg  <= s_tuser[hpwl_pkg::TUSER_ENABLE];
            s1_last_net_reg <= s_tuser[hpwl_pkg::TUSER_LAST_NET];
        end
    end

    // ---------------------------------------------------------------
    // Running bounding box
    // ---------------------------------------------------------------
    logic [CW-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [CW-1:0] px, py;
    logic [CW-1:0] min_x_upd, max_x_upd, min_y_upd, max_y_upd;

    // Out-of-range pins sit at the origin
    assign px = s1_in_range_reg ? rd_data[CW-1:0]    : '0;
    assign py = s1_in_range_reg ? rd_data[2*CW-1:CW] : '0;

    assign min_x_upd = (px < min_x_reg) ? px : min_x_reg;
    assign max_x_upd = (px > max_x_reg) ? px : max_x_reg;
    assign min_y_upd = (py < min_y_reg) ? py : min_y_reg;
    assign max_y_upd = (py > max_y_reg) ? py : max_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || s1_close) begin
            min_x_reg <= '1;
            max_x_reg <= '0;
            min_y_reg <= '1;
            max_y_reg <= '0;
        end else if (s1_fire) begin
            min_x_reg <= min_x_upd;
            max_x_reg <= max_x_upd;
            min_y_reg <= min_y_upd;
            max_y_reg <= max_y_upd;
        end
    end

    // Stage 2: final box of a closed net
    logic [CW-1:0] s2_min_x_reg, s2_max_x_reg, s2_min_y_reg, s2_max_y_reg;
    logic          s2_enabled_reg, s2_last_net_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_free) begin
            s2_valid_reg <= s1_close;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_free) begin
            s2_min_x_reg    <= min_x_upd;
            s2_max_x_reg    <= max_x_upd;
            s2_min_y_reg    <= min_y_upd;
            s2_max_y_reg    <= max_y_upd;
            s2_enabled_reg  <= s1_enabled_reg;
            s2_last_net_reg <= s1_last_net_reg;
        end
    end

    // Stage 3: half-perimeter, zero for a masked net
    logic [CW-1:0]  dx, dy;
    logic [WLW-1:0] wl_next;
    logic [WLW-1:0] s3_wl_reg;
    logic           s3_last_net_reg;

    assign dx      = s2_max_x_reg - s2_min_x_reg;
    assign dy      = s2_max_y_reg - s2_min_y_reg;
    assign wl_next = s2_enabled_reg ? (WLW'(dx) + WLW'(dy)) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_free) begin
            s3_valid_reg <= s2_move;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_free) begin
            s3_wl_reg       <= wl_next;
            s3_last_net_reg <= s2_last_net_reg;
        end
    end

    // ---------------------------------------------------------------
    // Saturating total and output register
    // ---------------------------------------------------------------
    hpwl_pkg::total_t              total_reg;
    hpwl_pkg::total_t              total_next;
    logic [hpwl_pkg::TOTAL_W:0]    sum_ext;
    hpwl_pkg::net_wl_t             m_net_wl_reg;
    hpwl_pkg::total_t              m_total_reg;
    logic                          m_last_reg;

    assign sum_ext    = {1'b0, total_reg} + (hpwl_pkg::TOTAL_W + 1)'(s3_wl_reg);
    assign total_next = sum_ext[hpwl_pkg::TOTAL_W] ? '1 : sum_ext[hpwl_pkg::TOTAL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s3_move) begin
                total_reg <= s3_last_net_reg ? '0 : total_next;
            end
            if (out_free) begin
                m_valid_reg <= s3_move;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_net_wl_reg <= hpwl_pkg::NET_WL_W'(s3_wl_reg);
            m_total_reg  <= total_next;
            m_last_reg   <= s3_last_net_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{hpwl_pkg::M_PAD_W{1'b0}}, m_total_reg, m_net_wl_reg};
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready))
        else $error("input stalled without a held result");

    a_total_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_move && s3_last_net_reg) |=> (total_reg == '0))
        else $error("total not cleared after last net");

    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && !s1_last_reg) |=> (min_x_reg <= max_x_reg && min_y_reg <= max_y_reg))
        else $error("running box inverted after a pin");

    a_masked_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_move && !s2_enabled_reg) |=> (s3_wl_reg == '0))
        else $error("masked net gave nonzero wirelength");

    a_box_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_close |=> (min_x_reg == '1 && max_x_reg == '0 && min_y_reg == '1
                      && max_y_reg == '0))
        else $error("running box not reset after net close");

endmodule

/* src/hpwl_ram.sv */
`timescale 1ns / 1ps

module hpwl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sim/hpwl_checker.sv */
`timescale 1ns / 1ps

module hpwl_checker (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [hpwl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [hpwl_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           s_tlast,

    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [hpwl_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,

    output int                             mismatches,
    output int                             results_due
);
    import hpwl_pkg::*;

    localparam int CELL_COUNT  = 65536;

    typedef struct {
        net_wl_t net_wl;
        total_t  total;
        logic    done;
    } net_result_t;

    logic [VAL_W-1:0] cell_x [0:CELL_COUNT-1];
    logic [VAL_W-1:0] cell_y [0:CELL_COUNT-1];
    logic [VAL_W-1:0] box_min_x, box_max_x, box_min_y, box_max_y;
    total_t           wl_total;
    net_result_t      wirelength_due[$];

    function automatic void clear_box();
        box_min_x = '1;
        box_max_x = '0;
        box_min_y = '1;
        box_max_y = '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Bounding-box and total prediction for one accepted input transaction
    function automatic void fold_transaction(input logic mode, input logic [IDX_W-1:0] idx,
                                             input logic [VAL_W-1:0] xv,
                                             input logic [VAL_W-1:0] yv,
                                             input logic en, input logic lp, input logic ln);
        logic [VAL_W-1:0]   px, py, dx, dy;
        net_wl_t            wl;
        logic [TOTAL_W:0]   sum;
        net_result_t        res;
        if (mode == MODE_WRITE) begin
            cell_x[idx] = xv;
            cell_y[idx] = yv;
            return;
        end
        px = cell_x[idx];
        py = cell_y[idx];
        if (px < box_min_x) box_min_x = px;
        if (px > box_max_x) box_max_x = px;
        if (py < box_min_y) box_min_y = py;
        if (py > box_max_y) box_max_y = py;
        if (!lp)
            return;
        dx = box_max_x - box_min_x;
        dy = box_max_y - box_min_y;
        wl = en ? ({1'b0, dx} + {1'b0, dy}) : '0;
        // saturate instead of wrapping
        sum = {1'b0, wl_total} + {{(TOTAL_W + 1 - NET_WL_W){1'b0}}, wl};
        wl_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        res.net_wl = wl;
        res.total  = wl_total;
        res.done   = ln;
        wirelength_due.push_back(res);
        clear_box();
        if (ln)
            wl_total = '0;
    endfunction

    always @(posedge aclk) begin
        net_result_t want;
        if (!aresetn) begin
            clear_box();
            wl_total = '0;
            wirelength_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (wirelength_due.size() == 0) begin
                    report_mismatch("result with none due",
                                    m_tdata[TOTAL_LSB +: TOTAL_W], '0);
                end else begin
                    want = wirelength_due.pop_front();
                    if (m_tdata[NET_WL_LSB +: NET_WL_W] !== want.net_wl)
                        report_mismatch("net_wirelength", 64'(m_tdata[NET_WL_LSB +: NET_WL_W]),
                                        64'(want.net_wl));
                    if (m_tdata[TOTAL_LSB +: TOTAL_W] !== want.total)
                        report_mismatch("total_wirelength", m_tdata[TOTAL_LSB +: TOTAL_W],
                                        want.total);
                    if (m_tlast !== want.done)
                        report_mismatch("design_done", 64'(m_tlast), 64'(want.done));
                end
            end
            if (s_tvalid && s_tready)
                fold_transaction(s_tuser[TUSER_MODE], s_tdata[IDX_LSB +: IDX_W],
                                 s_tdata[X_LSB +: VAL_W], s_tdata[Y_LSB +: VAL_W],
                                 s_tuser[TUSER_ENABLE], s_tlast, s_tuser[TUSER_LAST_NET]);
        end
        results_due <= wirelength_due.size();
    end

endmodule

/* sim/net_half_perimeter_wirelength_tb.sv */
`timescale 1ns / 1ps

module net_half_perimeter_wirelength_tb;
    import hpwl_pkg::*;

    localparam int PHASE_ITEMS = 480;
    localparam int HOLD_CYCLES = 80;
    localparam int POOL_MAX    = 256;
    localparam int DRAIN_WAIT  = 20;

    logic                 aclk;
    logic                 aresetn;

    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_tlast;

    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int mismatches;
    int results_due;
    int send_idle;      // percent of cycles the sender idles
    int recv_idle;      // percent of cycles the receiver stalls
    int holds_asked;
    int holds_done;
    int sent;

    // a pool of written cells; pins only ever name these
    logic [IDX_W-1:0] placed[$];

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    net_half_perimeter_wirelength u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    hpwl_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done != holds_asked) begin
                m_tready <= 1'b0;
                for (int n = 1; n < HOLD_CYCLES; n++)
                    @(negedge aclk);
                holds_done++;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Called at a falling edge, returns at a falling edge after acceptance
    task automatic send(input logic mode, input logic [IDX_W-1:0] idx,
                        input logic [VAL_W-1:0] xv, input logic [VAL_W-1:0] yv,
                        input logic en, input logic lp, input logic ln);
        logic [S_TDATA_W-1:0] data;
        logic [S_TUSER_W-1:0] user;
        data = '0;
        data[IDX_LSB +: IDX_W] = idx;
        data[X_LSB +: VAL_W]   = xv;
        data[Y_LSB +: VAL_W]   = yv;
        user[TUSER_MODE]       = mode;
        user[TUSER_ENABLE]     = en;
        user[TUSER_LAST_NET]   = ln;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= user;
        s_tlast  <= lp;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
    endtask

    function automatic logic [VAL_W-1:0] pick_coord();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Position write; the unused tuser/tlast bits carry noise
    task automatic write_cell(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] xv,
                              input logic [VAL_W-1:0] yv);
        send(MODE_WRITE, idx, xv, yv, 1'($urandom_range(1)), 1'($urandom_range(1)),
             1'($urandom_range(1)));
        if (placed.size() < POOL_MAX)
            placed.push_back(idx);
        else
            placed[$urandom_range(POOL_MAX - 1)] = idx;
    endtask

    // Pin transaction; x/y are don't-care here and get random bits
    task automatic pin(input logic [IDX_W-1:0] idx, input logic en, input logic lp,
                       input logic ln);
        send(MODE_PIN, idx, $urandom(), $urandom(), en, lp, ln);
    endtask

    // One net of random placed cells; stray writes may land mid-net
    task automatic run_net(input int pins);
        logic last;
        for (int p = 0; p < pins; p++) begin
            if ($urandom_range(99) < 5)
                write_cell(16'($urandom()), pick_coord(), pick_coord());
            last = (p == pins - 1);
            pin(placed[$urandom_range(placed.size() - 1)],
                last ? ($urandom_range(99) < 85) : 1'($urandom_range(1)),
                last,
                last ? ($urandom_range(99) < 8) : ($urandom_range(99) < 10));
        end
    endtask

    task automatic random_phase(input int items);
        int stop;
        int roll;
        stop = sent + items;
        while (sent < stop) begin
            roll = $urandom_range(99);
            if (roll < 15)
                write_cell(16'($urandom()), pick_coord(), pick_coord());
            else if (roll < 90)
                run_net($urandom_range(1, 4));
            else
                run_net($urandom_range(5, 16));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        send_idle   = 31;
        recv_idle   = 56;
        holds_asked = 0;
        sent        = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: corner coordinates, masking, enable sampling, design end
        write_cell(16'd0, '0, '0);
        send(MODE_WRITE, 16'hFFFF, '1, '1, 1'b1, 1'b1, 1'b1);   // last_net on a write: ignored
        placed.push_back(16'hFFFF);
        write_cell(16'd1234, 32'h0000_0100, 32'h8000_0000);
        pin(16'd0, 1'b1, 1'b1, 1'b0);                           // single-pin net
        pin(16'd0, 1'b1, 1'b0, 1'b0);
        pin(16'hFFFF, 1'b1, 1'b1, 1'b0);                        // widest box
        pin(16'hFFFF, 1'b1, 1'b0, 1'b1);                        // last_net without last pin
        pin(16'd0, 1'b0, 1'b1, 1'b0);                           // masked on the last pin
        pin(16'd1234, 1'b0, 1'b0, 1'b0);
        pin(16'd0, 1'b0, 1'b0, 1'b0);
        pin(16'hFFFF, 1'b1, 1'b1, 1'b1);                        // only last pin's enable counts
        pin(16'd1234, 1'b1, 1'b1, 1'b0);                        // total restarted
        write_cell(16'd1234, 32'hFFFF_FF00, '0);                // overwrite
        pin(16'd1234, 1'b1, 1'b0, 1'b0);
        pin(16'd0, 1'b1, 1'b1, 1'b0);
        pin(16'd0, 1'b1, 1'b0, 1'b0);
        pin(16'hFFFF, 1'b0, 1'b1, 1'b1);                        // masked net closes design

        random_phase(PHASE_ITEMS);

        send_idle = 56;
        recv_idle = 31;
        random_phase(PHASE_ITEMS);

        // No idling; receiver holds off long enough to back up the input
        send_idle = 0;
        recv_idle = 0;
        holds_asked++;
        random_phase(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        while (results_due != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
